FILE: rtl/core/sle_pkg.sv
`default_nettype none

package sle_pkg;

  localparam int DataW      = 32;
  localparam int FieldW     = 6;
  localparam int MaxResults = 32;

  localparam logic [FieldW-1:0] FoundNone = '1;

  typedef enum logic [3:0] {
    ActPushFront  = 4'd0,
    ActPushBack   = 4'd1,
    ActInsertAt   = 4'd2,
    ActPopFront   = 4'd3,
    ActPopBack    = 4'd4,
    ActEraseAt    = 4'd5,
    ActFind       = 4'd6,
    ActRemoveOne  = 4'd7,
    ActRemoveAll  = 4'd8,
    ActDump       = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StEmpty    = 3'd2,
    StBadPos   = 3'd3,
    StNotFound = 3'd4
  } status_e;

endpackage

`default_nettype wire

FILE: rtl/core/sequential_list_engine_top.sv
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// command  | start_i / busy_o   | action_i, position_i, value_i
// result   | strobe_o (1 cycle) | status_o, found_index_o, element_value_o,
//          |                    | element_count_o, last_o
//
// Checks that fail (full, empty, bad position), unknown actions and pop back
// answer in the cycle after the item. Insert, erase, pop front, find, remove and
// dump walk through the single-port-pair element memory, one entry per cycle,
// between the given position (or the front) and the end of the list.
// Dump emits one element per cycle. Reset empties the list; memory is not cleared.
// Results cannot be stalled.
`default_nettype none

module sequential_list_engine_top
  import sle_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [3:0]               action_i,
  input  wire logic [FieldW-1:0]        position_i,
  input  wire logic signed [DataW-1:0]  value_i,
  output logic                          strobe_o,
  output logic [2:0]                    status_o,
  output logic signed [FieldW-1:0]      found_index_o,
  output logic signed [DataW-1:0]       element_value_o,
  output logic [FieldW-1:0]             element_count_o,
  output logic                          last_o
);

  localparam int AW   = $clog2(LIST_DEPTH);
  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int CMPW = (CW > FieldW) ? CW : FieldW;

  typedef enum logic [1:0] {SIdle, SShUp, SWrVal, SWalk} state_e;
  typedef enum logic [2:0] {WkErase, WkFind, WkRmOne, WkRmAll, WkDump} walk_e;

  state_e state_q, state_d;
  walk_e  mode_q, mode_d;

  logic [CW-1:0]     cnt_q, cnt_d, r_q, r_d, j_q, j_d, lim_q, lim_d;
  logic [AW-1:0]     p_q, p_d, pos_q, pos_d, di_q, di_d, fi_q, fi_d;
  logic              dv_q, dv_d, hit_q, hit_d;
  logic [DataW-1:0]  val_q, val_d;

  logic              strobe_q, strobe_d, last_q, last_d;
  logic [2:0]        status_q, status_d;
  logic [FieldW-1:0] fidx_q, fidx_d, ecnt_q, ecnt_d;
  logic [DataW-1:0]  elem_q, elem_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DataW-1:0]  ram_wdata, rdata;

  logic [CMPW-1:0]   cnt_w, pos_w, ipos_w;
  logic              match, drop, fin, writes;
  action_e           act;

  sle_ram #(
    .Width(DataW),
    .Depth(LIST_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    r_d      = r_q;
    j_d      = j_q;
    lim_d    = lim_q;
    p_d      = p_q;
    pos_d    = pos_q;
    di_d     = di_q;
    fi_d     = fi_q;
    dv_d     = dv_q;
    hit_d    = hit_q;
    val_d    = val_q;
    strobe_d = 1'b0;
    last_d   = 1'b1;
    status_d = StOk;
    fidx_d   = '0;
    ecnt_d   = FieldW'(cnt_q);
    elem_d   = '0;

    ram_we    = 1'b0;
    ram_waddr = j_q[AW-1:0];
    ram_wdata = rdata;
    ram_raddr = r_q[AW-1:0];

    act    = action_e'(action_i);
    cnt_w  = CMPW'(cnt_q);
    pos_w  = CMPW'(position_i);
    ipos_w = pos_w;
    if (act == ActPushFront) begin
      ipos_w = '0;
    end else if (act == ActPushBack) begin
      ipos_w = cnt_w;
    end

    match  = (rdata == val_q);
    drop   = ((mode_q == WkErase) && (di_q == pos_q)) ||
             (((mode_q == WkRmOne) || (mode_q == WkFind)) && match && !hit_q) ||
             ((mode_q == WkRmAll) && match);
    writes = (mode_q == WkErase) || (mode_q == WkRmOne) || (mode_q == WkRmAll);
    fin    = dv_q && ((CW'(di_q) + CW'(1)) == lim_q);

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          strobe_d = 1'b1;
          val_d    = value_i;
          r_d      = '0;
          j_d      = '0;
          dv_d     = 1'b0;
          hit_d    = 1'b0;
          lim_d    = cnt_q;
          case (act)
            ActPushFront, ActPushBack, ActInsertAt: begin
              if (cnt_q == CW'(LIST_DEPTH)) begin
                status_d = StFull;
              end else if (ipos_w > cnt_w) begin
                status_d = StBadPos;
              end else begin
                strobe_d  = 1'b0;
                pos_d     = AW'(ipos_w);
                p_d       = AW'(cnt_q - CW'(1));
                ram_raddr = AW'(cnt_q - CW'(1));
                state_d   = (ipos_w == cnt_w) ? SWrVal : SShUp;
              end
            end
            ActPopFront, ActEraseAt: begin
              if (cnt_q == '0) begin
                status_d = StEmpty;
              end else if ((act == ActEraseAt) && (pos_w >= cnt_w)) begin
                status_d = StBadPos;
              end else begin
                strobe_d = 1'b0;
                pos_d    = (act == ActEraseAt) ? AW'(pos_w) : '0;
                r_d      = (act == ActEraseAt) ? CW'(pos_w) : '0;
                j_d      = (act == ActEraseAt) ? CW'(pos_w) : '0;
                mode_d   = WkErase;
                state_d  = SWalk;
              end
            end
            ActPopBack: begin
              if (cnt_q == '0) begin
                status_d = StEmpty;
              end else begin
                cnt_d  = cnt_q - CW'(1);
                ecnt_d = FieldW'(cnt_q - CW'(1));
              end
            end
            ActFind, ActRemoveOne, ActRemoveAll, ActDump: begin
              if (cnt_q == '0) begin
                status_d = StEmpty;
                fidx_d   = (act == ActFind) ? FoundNone : '0;
              end else begin
                strobe_d = 1'b0;
                state_d  = SWalk;
                unique case (act)
                  ActFind:      mode_d = WkFind;
                  ActRemoveOne: mode_d = WkRmOne;
                  ActRemoveAll: mode_d = WkRmAll;
                  default:      mode_d = WkDump;
                endcase
                if ((act == ActDump) && (cnt_w > CMPW'(MaxResults))) begin
                  lim_d = CW'(MaxResults);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      SShUp: begin
        ram_we    = 1'b1;
        ram_waddr = p_q + AW'(1);
        ram_wdata = rdata;
        if (p_q > pos_q) begin
          ram_raddr = p_q - AW'(1);
          p_d       = p_q - AW'(1);
        end else begin
          state_d = SWrVal;
        end
      end

      SWrVal: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = val_q;
        cnt_d     = cnt_q + CW'(1);
        strobe_d  = 1'b1;
        ecnt_d    = FieldW'(cnt_q + CW'(1));
        state_d   = SIdle;
      end

      SWalk: begin
        if (r_q < lim_q) begin
          r_d  = r_q + CW'(1);
          dv_d = 1'b1;
          di_d = r_q[AW-1:0];
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          if (mode_q == WkDump) begin
            strobe_d = 1'b1;
            elem_d   = rdata;
            last_d   = fin;
          end else if (drop) begin
            if (!hit_q) begin
              fi_d = di_q;
            end
            hit_d = 1'b1;
          end else if (writes) begin
            ram_we = 1'b1;
            j_d    = j_q + CW'(1);
          end
        end
        if (fin) begin
          state_d = SIdle;
          if (mode_q != WkDump) begin
            strobe_d = 1'b1;
            if (writes) begin
              cnt_d  = j_d;
              ecnt_d = FieldW'(j_d);
            end
            if ((mode_q != WkErase) && !hit_d) begin
              status_d = StNotFound;
            end
            if (mode_q == WkFind) begin
              fidx_d = hit_d ? FieldW'(fi_d) : FoundNone;
            end
          end
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      mode_q   <= WkErase;
      cnt_q    <= '0;
      r_q      <= '0;
      j_q      <= '0;
      lim_q    <= '0;
      dv_q     <= 1'b0;
      hit_q    <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      status_q <= StOk;
      fidx_q   <= '0;
      ecnt_q   <= '0;
      elem_q   <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      r_q      <= r_d;
      j_q      <= j_d;
      lim_q    <= lim_d;
      dv_q     <= dv_d;
      hit_q    <= hit_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
      status_q <= status_d;
      fidx_q   <= fidx_d;
      ecnt_q   <= ecnt_d;
      elem_q   <= elem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    pos_q <= pos_d;
    di_q  <= di_d;
    fi_q  <= fi_d;
    val_q <= val_d;
  end

  assign busy_o          = (state_q != SIdle);
  assign strobe_o        = strobe_q;
  assign status_o        = status_q;
  assign found_index_o   = fidx_q;
  assign element_value_o = elem_q;
  assign element_count_o = ecnt_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/sle_ram.sv
`default_nettype none

module sle_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sle_chk.sv
`default_nettype none

module sle_chk
  import sle_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    start_i,
  input wire logic                    busy_o,
  input wire logic                    strobe_o,
  input wire logic [2:0]              status_o,
  input wire logic [FieldW-1:0]       element_count_o,
  input wire logic                    last_o
);

  // accepted item either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || (strobe_o && last_o))
    else $error("item accepted without result or busy");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !busy_o)
    else $error("busy after final result");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy_o && (status_o == StOk))
    else $error("non-final result outside a dump");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == StFull) |-> element_count_o == FieldW'(LIST_DEPTH))
    else $error("full reported below capacity");

endmodule

bind sequential_list_engine_top sle_chk #(.LIST_DEPTH(LIST_DEPTH)) u_sle_chk (.*);

`default_nettype wire
